// File: hw/rtl/tsp_pkg.sv
package tsp_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int SLOT_W = 4;
	localparam int OP_W = 3;
	localparam int DATA_W = 32;

	localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
	localparam logic [OP_W-1:0] OP_START = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP = 3'd2;
	localparam logic [OP_W-1:0] OP_SETIV = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
	localparam logic [OP_W-1:0] OP_TICK = 3'd5;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_FIRE = 2'd1;
	localparam logic [1:0] KIND_DUE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVAL = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [DATA_W-1:0] ALL_ONES = '1;

	typedef enum logic [2:0] {
		CMD_CREATE,
		CMD_START,
		CMD_STOP,
		CMD_SETIV,
		CMD_DELETE,
		CMD_TICK,
		CMD_REJECT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] interval;
		logic repeat_req;
		logic [DATA_W-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] status;
		logic [SLOT_W-1:0] slot_out;
		logic [DATA_W-1:0] next_due;
		logic last;
	} result_t;

endpackage

// File: hw/rtl/tsp_in_if.sv
interface tsp_in_if;
	logic valid;
	logic ready;
	logic [tsp_pkg::OP_W-1:0] operation;
	logic [tsp_pkg::SLOT_W-1:0] slot;
	logic [tsp_pkg::DATA_W-1:0] interval;
	logic repeat_req;
	logic [tsp_pkg::DATA_W-1:0] now;

	modport source (output valid, output operation, output slot, output interval,
		output repeat_req, output now, input ready);
	modport sink (input valid, input operation, input slot, input interval,
		input repeat_req, input now, output ready);
endinterface

// File: hw/rtl/tsp_out_if.sv
interface tsp_out_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [1:0] status;
	logic [tsp_pkg::SLOT_W-1:0] slot_out;
	logic [tsp_pkg::DATA_W-1:0] next_due;
	logic last;

	modport source (output valid, output kind, output status, output slot_out,
		output next_due, output last, input ready);
	modport sink (input valid, input kind, input status, input slot_out,
		input next_due, input last, output ready);
endinterface

// File: hw/rtl/tsp_front.sv
module tsp_front #(
	parameter int SLOT_COUNT = tsp_pkg::SLOT_COUNT_DEF
) (
	tsp_in_if.sink req,
	output logic push_valid,
	output tsp_pkg::cmd_t push_cmd,
	input logic push_ready
);

	logic in_range;
	logic zero_iv;

	assign in_range = (int'(req.slot) < SLOT_COUNT);
	assign zero_iv = (req.interval == '0);
	assign push_valid = req.valid;
	assign req.ready = push_ready;

	// Checks that need no slot state are settled here, so the back end only
	// looks at the allocation bit.
	always_comb begin
		push_cmd.slot = req.slot;
		push_cmd.interval = req.interval;
		push_cmd.repeat_req = req.repeat_req;
		push_cmd.now = req.now;
		case (req.operation)
			tsp_pkg::OP_CREATE: begin
				push_cmd.op = zero_iv ? tsp_pkg::CMD_REJECT : tsp_pkg::CMD_CREATE;
			end
			tsp_pkg::OP_START: begin
				push_cmd.op = in_range ? tsp_pkg::CMD_START : tsp_pkg::CMD_REJECT;
			end
			tsp_pkg::OP_STOP: begin
				push_cmd.op = in_range ? tsp_pkg::CMD_STOP : tsp_pkg::CMD_REJECT;
			end
			tsp_pkg::OP_SETIV: begin
				push_cmd.op = (in_range && !zero_iv) ? tsp_pkg::CMD_SETIV
					: tsp_pkg::CMD_REJECT;
			end
			tsp_pkg::OP_DELETE: begin
				push_cmd.op = in_range ? tsp_pkg::CMD_DELETE : tsp_pkg::CMD_REJECT;
			end
			tsp_pkg::OP_TICK: begin
				push_cmd.op = tsp_pkg::CMD_TICK;
			end
			default: begin
				push_cmd.op = tsp_pkg::CMD_REJECT;
			end
		endcase
	end

endmodule

// File: hw/rtl/tsp_cmd_fifo.sv
module tsp_cmd_fifo (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	input tsp_pkg::cmd_t push_cmd,
	output logic push_ready,
	output logic pop_valid,
	output tsp_pkg::cmd_t pop_cmd,
	input logic pop_ready
);

	tsp_pkg::cmd_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_cmd = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// File: hw/rtl/tsp_exec.sv
module tsp_exec #(
	parameter int SLOT_COUNT = tsp_pkg::SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	input tsp_pkg::cmd_t pop_cmd,
	output logic pop_ready,
	tsp_out_if.source rsp
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SW = tsp_pkg::SLOT_W;
	localparam int DW = tsp_pkg::DATA_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_REPORT = 3'b100
	} state_t;

	state_t state_q;
	logic [IW-1:0] idx_q;
	tsp_pkg::cmd_t cmd_q;
	logic [DW-1:0] near_q;
	logic [SLOT_COUNT-1:0] alloc_q;
	logic [SLOT_COUNT-1:0] run_q;
	logic [SLOT_COUNT-1:0] per_q;
	logic [DW-1:0] period_mem [SLOT_COUNT];
	logic [DW-1:0] dl_mem [SLOT_COUNT];
	logic [DW-1:0] per_rd_q;
	logic [DW-1:0] dl_rd_q;
	tsp_pkg::result_t out_q;
	logic out_valid_q;

	logic out_free;
	logic [IW-1:0] sidx;
	logic [IW-1:0] rd_addr;
	logic cur_alloc;
	logic cur_run;
	logic cur_per;
	logic [DW-1:0] diff;
	logic [DW-1:0] rem;
	logic [DW-1:0] neg_per;
	logic active;
	logic fire;
	logic [DW-1:0] contrib;
	logic [SLOT_COUNT-1:0] free_oh;
	logic [IW-1:0] free_idx;
	logic full;
	logic is_tick;
	logic exec_op;
	logic tick_go;
	logic emit;
	tsp_pkg::result_t res_d;
	logic per_we;
	logic dl_we;
	logic [IW-1:0] wr_addr;
	logic [DW-1:0] per_wd;
	logic [DW-1:0] dl_wd;

	assign out_free = !out_valid_q || rsp.ready;
	assign sidx = IW'(pop_cmd.slot);
	assign is_tick = (cmd_q.op == tsp_pkg::CMD_TICK);
	assign pop_ready = (state_q == S_IDLE);

	assign cur_alloc = alloc_q[idx_q];
	assign cur_run = run_q[idx_q];
	assign cur_per = per_q[idx_q];

	// Wrap-safe compare: the deadline is reached when now - deadline is not
	// negative as a signed 32-bit value.
	assign diff = cmd_q.now - dl_rd_q;
	assign rem = dl_rd_q - cmd_q.now;
	assign neg_per = '0 - per_rd_q;
	assign active = cur_alloc && cur_run;
	assign fire = active && !diff[DW-1];

	// Remaining time of this slot after it has been handled. A rearmed slot
	// is due again in exactly its period, unless that period exceeds 2**31.
	always_comb begin
		if (!active) contrib = tsp_pkg::ALL_ONES;
		else if (fire && cur_per) contrib = neg_per[DW-1] ? per_rd_q : '0;
		else if (fire) contrib = tsp_pkg::ALL_ONES;
		else contrib = rem;
	end

	// Lowest clear bit of the allocation map.
	assign free_oh = ~alloc_q & (alloc_q + 1'b1);
	assign full = &alloc_q;
	always_comb begin
		free_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (free_oh[i]) free_idx = free_idx | IW'(i);
		end
	end

	assign exec_op = (state_q == S_EXEC) && !is_tick && out_free;
	assign tick_go = (state_q == S_EXEC) && is_tick && (!fire || out_free);

	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = (pop_cmd.op == tsp_pkg::CMD_TICK
				|| pop_cmd.op == tsp_pkg::CMD_REJECT) ? '0 : sidx;
		end else if (tick_go && idx_q != LAST_IDX) begin
			rd_addr = idx_q + 1'b1;
		end else begin
			rd_addr = idx_q;
		end
	end

	always_comb begin
		res_d = '0;
		res_d.last = 1'b1;
		emit = 1'b0;
		per_we = 1'b0;
		dl_we = 1'b0;
		wr_addr = idx_q;
		per_wd = cmd_q.interval;
		dl_wd = cmd_q.now + per_rd_q;
		if (exec_op) begin
			emit = 1'b1;
			res_d.kind = tsp_pkg::KIND_STATUS;
			res_d.status = cur_alloc ? tsp_pkg::ST_OK : tsp_pkg::ST_INVAL;
			case (cmd_q.op)
				tsp_pkg::CMD_CREATE: begin
					res_d.status = full ? tsp_pkg::ST_FULL : tsp_pkg::ST_OK;
					res_d.slot_out = full ? '0 : SW'(free_idx);
					per_we = !full;
					wr_addr = free_idx;
				end
				tsp_pkg::CMD_START: begin
					dl_we = cur_alloc;
				end
				tsp_pkg::CMD_SETIV: begin
					per_we = cur_alloc;
					dl_we = cur_alloc && cur_run;
					dl_wd = cmd_q.now + cmd_q.interval;
				end
				tsp_pkg::CMD_REJECT: begin
					res_d.status = tsp_pkg::ST_INVAL;
				end
				default: begin
				end
			endcase
		end else if (tick_go && fire) begin
			emit = 1'b1;
			res_d.kind = tsp_pkg::KIND_FIRE;
			res_d.slot_out = SW'(idx_q);
			res_d.last = 1'b0;
			dl_we = cur_per;
		end else if (state_q == S_REPORT && out_free) begin
			emit = 1'b1;
			res_d.kind = tsp_pkg::KIND_DUE;
			res_d.next_due = near_q;
		end
	end

	always_ff @(posedge clk) begin
		per_rd_q <= period_mem[rd_addr];
		dl_rd_q <= dl_mem[rd_addr];
		if (per_we) period_mem[wr_addr] <= per_wd;
		if (dl_we) dl_mem[wr_addr] <= dl_wd;
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= res_d;
		if (state_q == S_IDLE && pop_valid) cmd_q <= pop_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			near_q <= tsp_pkg::ALL_ONES;
			alloc_q <= '0;
			run_q <= '0;
			per_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !rsp.ready);
			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						idx_q <= rd_addr;
						near_q <= tsp_pkg::ALL_ONES;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_op) begin
						state_q <= S_IDLE;
						case (cmd_q.op)
							tsp_pkg::CMD_CREATE: begin
								if (!full) begin
									alloc_q[free_idx] <= 1'b1;
									run_q[free_idx] <= 1'b0;
									per_q[free_idx] <= cmd_q.repeat_req;
								end
							end
							tsp_pkg::CMD_START: begin
								if (cur_alloc) run_q[idx_q] <= 1'b1;
							end
							tsp_pkg::CMD_STOP: begin
								if (cur_alloc) run_q[idx_q] <= 1'b0;
							end
							tsp_pkg::CMD_DELETE: begin
								if (cur_alloc) begin
									alloc_q[idx_q] <= 1'b0;
									run_q[idx_q] <= 1'b0;
									per_q[idx_q] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end else if (tick_go) begin
						if (fire && !cur_per) run_q[idx_q] <= 1'b0;
						if (contrib < near_q) near_q <= contrib;
						idx_q <= rd_addr;
						if (idx_q == LAST_IDX) state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.kind = out_q.kind;
	assign rsp.status = out_q.status;
	assign rsp.slot_out = out_q.slot_out;
	assign rsp.next_due = out_q.next_due;
	assign rsp.last = out_q.last;

`ifndef SYNTH
	a_run_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q & ~alloc_q) == '0)
		else $error("running slot is not allocated");

	a_report_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REPORT |-> idx_q == LAST_IDX)
		else $error("report entered before the walk ended");

	a_due_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res_d.kind == tsp_pkg::KIND_DUE |=> state_q == S_IDLE)
		else $error("next-due report did not end the tick");

	a_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && is_tick && idx_q != LAST_IDX && tick_go
		|=> state_q == S_EXEC && idx_q == $past(idx_q) + 1'b1)
		else $error("tick walk skipped a slot");
`endif

endmodule

// File: hw/rtl/timer_slot_pool.sv
// Pool of SLOT_COUNT millisecond timer slots driven by one operation per req
// transfer: create, start, stop, set interval, delete and tick. Every non-tick
// operation answers one status result; a tick answers one fired result per
// expiring slot in slot order, then a next-due report flagged with last. The
// front end classifies operations into a two-entry queue, so req may take up
// to two operations while the back end works. The back end takes a
// non-tick operation through its execute state; a tick walks one slot per
// cycle, through the single read port of the period and deadline memories,
// then gives the report. A full response register stalls a firing slot, a
// status result or the report. There is no clearing pass after reset.
module timer_slot_pool #(
	parameter int SLOT_COUNT = tsp_pkg::SLOT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	tsp_in_if.sink req,
	tsp_out_if.source rsp
);

	logic push_valid;
	logic push_ready;
	tsp_pkg::cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	tsp_pkg::cmd_t pop_cmd;

	tsp_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
		.req(req),
		.push_valid(push_valid),
		.push_cmd(push_cmd),
		.push_ready(push_ready)
	);

	tsp_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_cmd(push_cmd),
		.push_ready(push_ready),
		.pop_valid(pop_valid),
		.pop_cmd(pop_cmd),
		.pop_ready(pop_ready)
	);

	tsp_exec #(.SLOT_COUNT(SLOT_COUNT)) u_exec (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_cmd(pop_cmd),
		.pop_ready(pop_ready),
		.rsp(rsp)
	);

endmodule
